### hdl/vsd_pkg.sv
// Shared types and constants for the voxel stream decoder.
// Holds the parse phase enum, the cursor control group and the result beat layout.
// No dependencies.
package vsd_pkg;

  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned AXES       = 3;

  localparam logic [7:0] ALPHA_EMPTY  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_VOXEL  = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [4:0] {
    PH_SIZE0  = 5'd0,
    PH_SIZE1  = 5'd1,
    PH_SIZE2  = 5'd2,
    PH_VERT0  = 5'd3,
    PH_VERT1  = 5'd4,
    PH_VERT2  = 5'd5,
    PH_VERT3  = 5'd6,
    PH_INDEX0 = 5'd7,
    PH_INDEX1 = 5'd8,
    PH_INDEX2 = 5'd9,
    PH_INDEX3 = 5'd10,
    PH_ALPHA  = 5'd11,
    PH_POS0   = 5'd12,
    PH_POS1   = 5'd13,
    PH_POS2   = 5'd14,
    PH_ALPHA2 = 5'd15,
    PH_RED    = 5'd16,
    PH_GREEN  = 5'd17,
    PH_BLUE   = 5'd18
  } phase_t;

  // One byte per axis: x in [0], y in [1], z in [2].
  typedef logic [AXES-1:0][7:0] coord3_t;

  // Parser to cursor unit.
  typedef struct packed {
    logic       clear;     // file start: zero the cursor, drop any advance
    logic       cancel;    // zero alpha: new position follows, drop any advance
    logic       load;      // position byte for one axis
    logic [1:0] load_idx;
    logic [7:0] load_val;
    logic       start;     // voxel emitted: begin the wrapped advance
  } cursor_ctl_t;

  // Result beat, pos_x in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] index_total;
    logic [31:0] vertex_total;
    logic        opaque;
    logic [7:0]  alpha;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  pos_z;
    logic [7:0]  pos_y;
    logic [7:0]  pos_x;
  } result_t;

endpackage

### hdl/vsd_cursor.sv
// Voxel cursor registers and the wrapped advance unit.
// Three remainder lanes run three restoring steps per cycle; uses vsd_pkg.
module vsd_cursor
  import vsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  coord3_t     extent,
  input  cursor_ctl_t ctl,
  output coord3_t     cursor
);

  localparam logic [1:0] LAST_STEP = 2'd2;
  localparam int unsigned BITS_PER_STEP = 3;

  coord3_t                pos_r, pos_nxt;
  logic                   busy_r, busy_nxt;
  logic [1:0]             step_r, step_nxt;
  logic [AXES-1:0][8:0]   num_r, num_nxt;
  logic [AXES-1:0][8:0]   div_r, div_nxt;
  logic [AXES-1:0][7:0]   rem_r, rem_nxt;
  logic [AXES-1:0][8:0]   num_s;
  logic [AXES-1:0][7:0]   rem_s;

  // Three restoring remainder steps per lane and cycle.
  always_comb begin
    logic [8:0] trial;
    for (int a = 0; a < AXES; a++) begin
      num_s[a] = num_r[a];
      rem_s[a] = rem_r[a];
      for (int k = 0; k < BITS_PER_STEP; k++) begin
        trial = {rem_s[a], num_s[a][8]};
        if (trial >= div_r[a]) begin
          trial = trial - div_r[a];
        end
        rem_s[a] = trial[7:0];
        num_s[a] = {num_s[a][7:0], 1'b0};
      end
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    busy_nxt = busy_r;
    step_nxt = step_r;
    num_nxt  = num_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (ctl.clear) begin
      pos_nxt  = '0;
      busy_nxt = 1'b0;
    end else if (ctl.load) begin
      busy_nxt = 1'b0;
      case (ctl.load_idx)
        AXIS_X:  pos_nxt[0] = ctl.load_val;
        AXIS_Y:  pos_nxt[1] = ctl.load_val;
        AXIS_Z:  pos_nxt[2] = ctl.load_val;
        default: pos_nxt = pos_r;
      endcase
    end else if (ctl.cancel) begin
      busy_nxt = 1'b0;
    end else if (ctl.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      for (int a = 0; a < AXES; a++) begin
        num_nxt[a] = {1'b0, pos_r[a]} + 9'd1;
        div_nxt[a] = (extent[a] == 8'd0) ? 9'd256 : {1'b0, extent[a]};
        rem_nxt[a] = '0;
      end
    end else if (busy_r) begin
      num_nxt  = num_s;
      rem_nxt  = rem_s;
      step_nxt = step_r + 2'd1;
      if (step_r == LAST_STEP) begin
        // Carry x into y and y into z only on wrap to zero.
        busy_nxt   = 1'b0;
        pos_nxt[0] = rem_s[0];
        if (rem_s[0] == 8'd0) begin
          pos_nxt[1] = rem_s[1];
          if (rem_s[1] == 8'd0) begin
            pos_nxt[2] = rem_s[2];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign cursor = pos_r;

endmodule

### hdl/vsd_parser.sv
// Byte parser: header fields, voxel alpha/position/colour bytes, result composition.
// Drives the cursor unit through cursor_ctl_t; uses vsd_pkg.
module vsd_parser
  import vsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  input  coord3_t     cursor,
  output coord3_t     extent,
  output cursor_ctl_t ctl,
  output logic        res_valid,
  output logic        res_kind,
  output result_t     res
);

  phase_t      phase_r, phase_nxt, ph;
  coord3_t     ext_r, ext_nxt, ext_b;
  logic [31:0] vert_r, vert_nxt, vert_b;
  logic [31:0] shift_r, shift_nxt, shift_b, shift_in;
  logic [7:0]  alpha_r, alpha_nxt, alpha_b;
  logic [7:0]  red_r, red_nxt, red_b;
  logic [7:0]  green_r, green_nxt, green_b;

  // File start restarts at the first size byte with cleared state.
  assign ph       = file_start ? PH_SIZE0 : phase_r;
  assign ext_b    = file_start ? '0 : ext_r;
  assign vert_b   = file_start ? '0 : vert_r;
  assign shift_b  = file_start ? '0 : shift_r;
  assign alpha_b  = file_start ? '0 : alpha_r;
  assign red_b    = file_start ? '0 : red_r;
  assign green_b  = file_start ? '0 : green_r;
  assign shift_in = {data_byte, shift_b[31:8]};

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      case (ph)
        PH_SIZE0:  phase_nxt = PH_SIZE1;
        PH_SIZE1:  phase_nxt = PH_SIZE2;
        PH_SIZE2:  phase_nxt = PH_VERT0;
        PH_VERT0:  phase_nxt = PH_VERT1;
        PH_VERT1:  phase_nxt = PH_VERT2;
        PH_VERT2:  phase_nxt = PH_VERT3;
        PH_VERT3:  phase_nxt = PH_INDEX0;
        PH_INDEX0: phase_nxt = PH_INDEX1;
        PH_INDEX1: phase_nxt = PH_INDEX2;
        PH_INDEX2: phase_nxt = PH_INDEX3;
        PH_INDEX3: phase_nxt = PH_ALPHA;
        PH_ALPHA:  phase_nxt = (data_byte == ALPHA_EMPTY) ? PH_POS0 : PH_RED;
        PH_POS0:   phase_nxt = PH_POS1;
        PH_POS1:   phase_nxt = PH_POS2;
        PH_POS2:   phase_nxt = PH_ALPHA2;
        PH_ALPHA2: phase_nxt = PH_RED;
        PH_RED:    phase_nxt = PH_GREEN;
        PH_GREEN:  phase_nxt = PH_BLUE;
        PH_BLUE:   phase_nxt = PH_ALPHA;
        default:   phase_nxt = PH_SIZE0;
      endcase
    end
  end

  // Held fields, cursor control and the result of this beat.
  always_comb begin
    ext_nxt      = ext_b;
    vert_nxt     = vert_b;
    shift_nxt    = shift_b;
    alpha_nxt    = alpha_b;
    red_nxt      = red_b;
    green_nxt    = green_b;
    res_valid    = 1'b0;
    res_kind     = KIND_HEADER;
    res          = '0;
    ctl          = '0;
    ctl.clear    = acc & file_start;
    ctl.load_val = data_byte;
    case (ph)
      PH_SIZE0: ext_nxt[0] = data_byte;
      PH_SIZE1: ext_nxt[1] = data_byte;
      PH_SIZE2: ext_nxt[2] = data_byte;
      PH_VERT0, PH_VERT1, PH_VERT2, PH_INDEX0, PH_INDEX1, PH_INDEX2: begin
        shift_nxt = shift_in;
      end
      PH_VERT3: begin
        vert_nxt  = shift_in;
        shift_nxt = '0;
      end
      PH_INDEX3: begin
        shift_nxt        = shift_in;
        res_valid        = acc;
        res_kind         = KIND_HEADER;
        res.pos_x        = ext_b[0];
        res.pos_y        = ext_b[1];
        res.pos_z        = ext_b[2];
        res.vertex_total = vert_b;
        res.index_total  = shift_in;
      end
      PH_ALPHA: begin
        alpha_nxt  = data_byte;
        ctl.cancel = acc && (data_byte == ALPHA_EMPTY);
      end
      PH_POS0: begin
        ctl.load     = acc;
        ctl.load_idx = AXIS_X;
      end
      PH_POS1: begin
        ctl.load     = acc;
        ctl.load_idx = AXIS_Y;
      end
      PH_POS2: begin
        ctl.load     = acc;
        ctl.load_idx = AXIS_Z;
      end
      PH_ALPHA2: alpha_nxt = data_byte;
      PH_RED:    red_nxt   = data_byte;
      PH_GREEN:  green_nxt = data_byte;
      PH_BLUE: begin
        res_valid  = acc;
        res_kind   = KIND_VOXEL;
        res.pos_x  = cursor[0];
        res.pos_y  = cursor[1];
        res.pos_z  = cursor[2];
        res.red    = red_b;
        res.green  = green_b;
        res.blue   = data_byte;
        res.alpha  = alpha_b;
        res.opaque = (alpha_b == ALPHA_OPAQUE);
        ctl.start  = acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE0;
      ext_r   <= '0;
      vert_r  <= '0;
      shift_r <= '0;
      alpha_r <= '0;
      red_r   <= '0;
      green_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (acc) begin
        ext_r   <= ext_nxt;
        vert_r  <= vert_nxt;
        shift_r <= shift_nxt;
        alpha_r <= alpha_nxt;
        red_r   <= red_nxt;
        green_r <= green_nxt;
      end
    end
  end

  assign extent = ext_r;

endmodule

### hdl/vsd_out_reg.sv
// Result register between the parser and the master-side stream.
// Holds one beat and frees itself in the cycle the beat is taken; uses vsd_pkg.
module vsd_out_reg
  import vsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  res_kind,
  input  result_t               res,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic                  out_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  slot_free
);

  logic    valid_r, valid_nxt;
  logic    kind_r;
  result_t data_r;

  assign slot_free = !valid_r || out_tready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res_kind;
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = OUT_DATA_W'(data_r);

endmodule

### hdl/voxel_stream_decoder.sv
// Voxel stream decoder, top level: byte parser, cursor unit and result register.
// Depends on vsd_pkg, vsd_parser, vsd_cursor and vsd_out_reg.
//
// Takes a voxel model file one byte per beat on the slave side and produces header and
// voxel results on the master side. The first 11 bytes of a file are the x, y and z sizes
// followed by the little-endian vertex and index counts; the 11th byte yields one header
// result (tuser = 0). After that each voxel is an alpha byte, then, if alpha was zero, three
// position bytes and a second alpha byte taken as is, then red, green and blue; the blue byte
// yields one voxel result (tuser = 1) at the current cursor, opaque set for alpha 255.
// The cursor then steps x, carrying into y and z on wrap, modulo each size (0 means 256).
// A beat with in_tuser high restarts the parse at the first size byte with cleared state;
// an unfinished voxel or header produces nothing. Throughput is one byte per cycle: a result
// leaves the parser in the cycle its last byte is accepted and waits in the result register,
// and in_tready only drops while that register holds a beat that out_tready does not take.
// out_tvalid rises in the cycle after the last byte of an item is accepted. The cursor
// step is a remainder computation by a three-bit-per-cycle restoring unit, which finishes
// before the next voxel's blue byte can arrive unless a zero alpha or file start drops it.
module voxel_stream_decoder
  import vsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // slave side
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] file_start
  // master side
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pos_x, pos_y, pos_z, red, green, blue, alpha,
                                            // opaque, vertex_total, index_total, zero pad
  output logic                  out_tuser   // [0] kind
);

  logic        in_acc;
  logic        res_valid;
  logic        res_kind;
  result_t     res;
  coord3_t     extent;
  coord3_t     cursor;
  cursor_ctl_t cur_ctl;
  result_t     out_beat;

  // Accept a byte whenever the result register can take whatever it yields.
  assign in_acc = in_tvalid && in_tready;

  vsd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .data_byte  (in_tdata),
    .file_start (in_tuser),
    .cursor     (cursor),
    .extent     (extent),
    .ctl        (cur_ctl),
    .res_valid  (res_valid),
    .res_kind   (res_kind),
    .res        (res)
  );

  // Cursor registers plus the wrapped advance after each voxel.
  vsd_cursor u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .extent (extent),
    .ctl    (cur_ctl),
    .cursor (cursor)
  );

  // Hold the finished beat until the master side takes it.
  vsd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res_kind   (res_kind),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .slot_free  (in_tready)
  );

  assign out_beat = result_t'(out_tdata);

  // An empty result register never stalls the byte stream.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // Header beats carry no colour.
  a_header_no_colour : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_HEADER) |->
      (out_beat.red == 8'd0 && out_beat.green == 8'd0 && out_beat.blue == 8'd0 &&
       out_beat.alpha == 8'd0 && !out_beat.opaque))
    else $error("header beat with colour fields set");

  // Voxel beats carry no counts.
  a_voxel_no_counts : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_VOXEL) |->
      (out_beat.vertex_total == 32'd0 && out_beat.index_total == 32'd0))
    else $error("voxel beat with count fields set");

  // Opaque follows alpha.
  a_opaque_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_VOXEL) |->
      (out_beat.opaque == (out_beat.alpha == ALPHA_OPAQUE)))
    else $error("opaque flag disagrees with alpha");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for voxel_stream_decoder: byte stream in, header and voxel beats out.
// Depends on vsd_pkg and the voxel_stream_decoder RTL; runs directed files, then random
// files under several idle and stall mixes.
`timescale 1ns / 100ps

module testbench;
  import vsd_pkg::*;

  // Expected beat: kind travels on tuser, the rest on tdata.
  typedef struct packed {
    logic    kind;
    result_t res;
  } voxel_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Predictor state.
  phase_t      ph;
  coord3_t     dims;
  coord3_t     at;
  logic [31:0] vtx_word;
  logic [31:0] shift_word;
  logic [7:0]  held_alpha;
  logic [7:0]  held_red;
  logic [7:0]  held_green;

  voxel_beat_t pending_results[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int files_started = 0;
  int headers_seen = 0;
  int voxels_seen = 0;
  int results_checked = 0;
  int mismatches = 0;

  voxel_stream_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side at the current rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic coord3_t xyz(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z);
    coord3_t c;
    c[AXIS_X] = x;
    c[AXIS_Y] = y;
    c[AXIS_Z] = z;
    return c;
  endfunction

  // One axis step: modulo the size, a size of 0 counting as 256.
  function automatic logic [7:0] step_axis(input logic [7:0] v, input logic [7:0] dim);
    int m;
    m = (dim == 8'd0) ? 256 : int'(dim);
    return 8'((int'(v) + 1) % m);
  endfunction

  task automatic clear_file();
    ph         = PH_SIZE0;
    dims       = '0;
    at         = '0;
    vtx_word   = '0;
    shift_word = '0;
    held_alpha = '0;
    held_red   = '0;
    held_green = '0;
  endtask

  // Advance the parse by one accepted byte and queue any beat it completes.
  task automatic decode_byte(input logic [7:0] b, input logic fs);
    voxel_beat_t d;
    d = '0;
    if (fs) clear_file();
    if (ph < PH_VERT0) begin
      dims[ph] = b;
      ph = phase_t'(ph + 1);
    end else if (ph < PH_ALPHA) begin
      shift_word = (shift_word >> 8) | {b, 24'h0};
      ph = phase_t'(ph + 1);
      if (ph == PH_INDEX0) begin
        vtx_word   = shift_word;
        shift_word = '0;
      end else if (ph == PH_ALPHA) begin
        d.kind             = KIND_HEADER;
        d.res.pos_x        = dims[AXIS_X];
        d.res.pos_y        = dims[AXIS_Y];
        d.res.pos_z        = dims[AXIS_Z];
        d.res.vertex_total = vtx_word;
        d.res.index_total  = shift_word;
        pending_results.push_back(d);
      end
    end else if (ph == PH_ALPHA) begin
      held_alpha = b;
      ph = (b == ALPHA_EMPTY) ? PH_POS0 : PH_RED;
    end else if (ph >= PH_POS0 && ph < PH_ALPHA2) begin
      at[ph - PH_POS0] = b;
      ph = phase_t'(ph + 1);
    end else if (ph == PH_ALPHA2) begin
      // second alpha is taken as is, zero included
      held_alpha = b;
      ph = PH_RED;
    end else if (ph == PH_RED) begin
      held_red = b;
      ph = PH_GREEN;
    end else if (ph == PH_GREEN) begin
      held_green = b;
      ph = PH_BLUE;
    end else begin
      d.kind       = KIND_VOXEL;
      d.res.pos_x  = at[AXIS_X];
      d.res.pos_y  = at[AXIS_Y];
      d.res.pos_z  = at[AXIS_Z];
      d.res.red    = held_red;
      d.res.green  = held_green;
      d.res.blue   = b;
      d.res.alpha  = held_alpha;
      d.res.opaque = (held_alpha == ALPHA_OPAQUE);
      pending_results.push_back(d);
      // carry x into y into z only on wrap
      at[AXIS_X] = step_axis(at[AXIS_X], dims[AXIS_X]);
      if (at[AXIS_X] == 8'd0) begin
        at[AXIS_Y] = step_axis(at[AXIS_Y], dims[AXIS_Y]);
        if (at[AXIS_Y] == 8'd0) at[AXIS_Z] = step_axis(at[AXIS_Z], dims[AXIS_Z]);
      end
      ph = PH_ALPHA;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: result %0d, %s: got %h, want %h", $time, results_checked, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    voxel_beat_t want;
    result_t     got;
    got = result_t'(out_tdata);
    if (pending_results.size() == 0) begin
      report_mismatch("beat with nothing expected, kind", 32'(out_tuser), 32'd0);
      return;
    end
    want = pending_results.pop_front();
    compare_field("kind", 32'(out_tuser), 32'(want.kind));
    compare_field("pos_x", 32'(got.pos_x), 32'(want.res.pos_x));
    compare_field("pos_y", 32'(got.pos_y), 32'(want.res.pos_y));
    compare_field("pos_z", 32'(got.pos_z), 32'(want.res.pos_z));
    compare_field("red", 32'(got.red), 32'(want.res.red));
    compare_field("green", 32'(got.green), 32'(want.res.green));
    compare_field("blue", 32'(got.blue), 32'(want.res.blue));
    compare_field("alpha", 32'(got.alpha), 32'(want.res.alpha));
    compare_field("opaque", 32'(got.opaque), 32'(want.res.opaque));
    compare_field("vertex_total", got.vertex_total, want.res.vertex_total);
    compare_field("index_total", got.index_total, want.res.index_total);
    compare_field("pad", 32'(got.pad), 32'd0);
    if (want.kind == KIND_HEADER) headers_seen++;
    else voxels_seen++;
    results_checked++;
  endtask

  // Check outputs before predicting, so a beat never meets an expectation from the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_file();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
    end
  end

  // Offer one byte, idling first at the current rate, and hold it until accepted.
  task automatic send_beat(input logic [7:0] b, input logic fs);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Send the first cut bytes of a header; 11 sends it whole.
  task automatic send_header(input coord3_t size, input logic [31:0] verts,
                             input logic [31:0] idx, input int cut);
    logic [7:0] hdr[11];
    hdr[0] = size[AXIS_X];
    hdr[1] = size[AXIS_Y];
    hdr[2] = size[AXIS_Z];
    for (int i = 0; i < 4; i++) begin
      hdr[3 + i] = verts[8*i +: 8];
      hdr[7 + i] = idx[8*i +: 8];
    end
    for (int i = 0; i < cut && i < 11; i++) send_beat(hdr[i], i == 0);
    files_started++;
  endtask

  // Send the first cut bytes of a voxel; a relocating voxel sends a zero alpha, the
  // position, then alpha as its second alpha byte.
  task automatic send_voxel(input logic reloc, input logic [7:0] alpha, input coord3_t where,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input int cut);
    logic [7:0] seq[$];
    if (reloc) seq = '{ALPHA_EMPTY, where[AXIS_X], where[AXIS_Y], where[AXIS_Z], alpha, r, g, b};
    else seq = '{alpha, r, g, b};
    for (int i = 0; i < cut && i < seq.size(); i++) send_beat(seq[i], 1'b0);
  endtask

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly tiny sizes so the cursor wraps often; now and then 0 (256), 255 or anything.
  function automatic logic [7:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_random_voxel(input coord3_t size, input int cut);
    coord3_t    where;
    logic [7:0] a;
    logic       reloc;
    reloc = ($urandom_range(0, 99) < 20);
    for (int i = 0; i < AXES; i++) begin
      if ($urandom_range(0, 3) == 0 || size[i] == 8'd0) where[i] = 8'($urandom_range(0, 255));
      else where[i] = 8'($urandom_range(0, int'(size[i]) - 1));
    end
    if (reloc) begin
      a = ($urandom_range(0, 3) == 0) ? ALPHA_EMPTY : edge_byte();
    end else begin
      case ($urandom_range(0, 3))
        0: a = ALPHA_OPAQUE;
        1: a = 8'h01;
        default: a = 8'($urandom_range(1, 255));
      endcase
    end
    send_voxel(reloc, a, where, edge_byte(), edge_byte(), edge_byte(), cut);
  endtask

  // Extreme sizes and counts in one header.
  task automatic test_header_fields();
    gap_pct   = 0;
    stall_pct = 0;
    send_header(xyz(8'd0, 8'd255, 8'd1), 32'hFFFF_FFFF, 32'h0000_0000, 11);
  endtask

  // Opaque voxel, relocation with a zero second alpha to the far corner, the full
  // x-y-z wrap chain, then a truncated voxel that the next file start drops.
  task automatic test_voxel_paths();
    send_voxel(1'b0, ALPHA_OPAQUE, '0, 8'h00, 8'hFF, 8'h5A, 8);
    send_voxel(1'b1, ALPHA_EMPTY, xyz(8'd255, 8'd254, 8'd0), 8'hFF, 8'h00, 8'hFF, 8);
    send_voxel(1'b0, 8'h01, '0, 8'h80, 8'h7F, 8'h01, 8);
    send_voxel(1'b0, 8'hFE, '0, 8'h12, 8'h34, 8'h56, 2);
  endtask

  // Random files: mostly whole headers and voxels, some cut short, some noise.
  task automatic test_random_files(input int gap, input int stall, input int budget);
    int      stop_at;
    coord3_t size;
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = beats_sent + budget;
    while (beats_sent < stop_at) begin
      size = xyz(pick_size(), pick_size(), pick_size());
      if ($urandom_range(0, 99) < 8) begin
        send_header(size, rand_word(), rand_word(), $urandom_range(1, 10));
        continue;
      end
      send_header(size, rand_word(), rand_word(), 11);
      repeat ($urandom_range(0, 10)) send_random_voxel(size, 8);
      if ($urandom_range(0, 9) < 3) send_random_voxel(size, $urandom_range(1, 7));
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 6))
          send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_fields();
    test_voxel_paths();
    test_random_files(0, 0, 300);
    test_random_files(45, 0, 300);
    test_random_files(0, 45, 300);
    test_random_files(23, 23, 300);
    in_tvalid <= 1'b0;

    // drain, then allow for the result register and the cursor step
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("expected beats never seen", 32'(pending_results.size()), 32'd0);

    $display("Sent %0d bytes over %0d files; checked %0d header and %0d voxel beats.",
             beats_sent, files_started, headers_seen, voxels_seen);
    $display("Idle mixes: none, sender 45%%, receiver 45%%, both 23%%; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("voxel_stream_decoder regression: pass");
    end else begin
      $display("voxel_stream_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("voxel_stream_decoder regression: fail");
    $finish;
  end

endmodule
